// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants of the SHA-1 message hasher
// Initial hash values, round constants, state types and the control and
// status bundles between the sequencer and the compression core.
// ----------------------------------------------------------------------------
package sha1_pkg;

   typedef logic [31:0]       word_type;
   typedef word_type [4:0]    chain_type;
   typedef word_type [15:0]   block_type;

   // SHA-1 initial hash values H0..H4
   localparam chain_type SHA_INIT = '{
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   // round constants, one per group of 20 rounds
   localparam word_type K_GROUP0 = 32'h5A827999;
   localparam word_type K_GROUP1 = 32'h6ED9EBA1;
   localparam word_type K_GROUP2 = 32'h8F1BBCDC;
   localparam word_type K_GROUP3 = 32'hCA62C1D6;

   localparam logic [6:0] ROUND_GROUP1 = 7'd20;
   localparam logic [6:0] ROUND_GROUP2 = 7'd40;
   localparam logic [6:0] ROUND_GROUP3 = 7'd60;
   localparam logic [6:0] ROUND_LAST   = 7'd79;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [7:0] PAD_ZERO  = 8'h00;
   localparam logic [5:0] POS_LEN   = 6'd56;
   localparam logic [5:0] POS_LAST  = 6'd63;
   localparam logic [2:0] OUT_LAST  = 3'd4;
   localparam logic [63:0] BYTE_BITS = 64'd8;

   // compression core sequencer
   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_LOAD,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   // message sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PAD,
      ST_LEN,
      ST_FINAL,
      ST_OUT
   } hash_state_type;

   typedef struct packed {
      logic start;    // compress block_words with the current chaining value
      logic restore;  // reload the initial hash values
   } core_ctrl_type;

   typedef struct packed {
      logic busy;     // a block is in compression
      logic done;     // chaining value is updated at this edge
   } core_stat_type;

endpackage

// ===== sv/sha1_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_message_hasher: streaming SHA-1 message hasher
// Packs message bytes big-endian into 64-byte blocks, pads the message with
// 0x80, zeros and the 64-bit bit count, and returns the five digest words.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tuser        | tlast
//  req_    | in  | [7:0] data_byte       | byte_present | message_end
//  rsp_    | out | [31:0] digest_word    | -            | digest_last
//
//  A byte that fills the block starts a compression in the shared round
//  unit (load, 80 rounds and the add). At message end padding bytes go in
//  one per cycle (up to 64) except while a full block is compressed; the
//  length slot is checked, the bit count written, the last block compressed;
//  then five digest words, one per cycle while rsp_tready is high.
//  Reset is synchronous: chaining value returns to the initial hash values,
//  bit count and byte position clear.
//  req_tready is low while busy; a low rsp_tready holds the digest word.
// ----------------------------------------------------------------------------
module sha1_message_hasher
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast    // digest_last
);

   hash_state_type state_ff, state_in;
   logic [5:0]     pos_ff, pos_in;
   logic [63:0]    count_ff, count_in;
   logic           pend_ff, pend_in;     // message end waits behind a block
   logic           mark_ff, mark_in;     // 0x80 byte still to be placed
   logic [2:0]     idx_ff, idx_in;
   block_type      block_ff;

   logic          wr_en;
   logic [7:0]    wr_byte;
   logic          len_wr;
   logic [3:0]    wr_word;
   logic [1:0]    wr_lane;
   word_type      lane_val;
   core_ctrl_type core_ctrl;
   core_stat_type core_stat;
   chain_type     chain;
   logic          req_acc;
   logic          rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // message sequencer
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      mark_in    = mark_ff;
      idx_in     = idx_ff;
      wr_en      = 1'b0;
      wr_byte    = req_tdata;
      len_wr     = 1'b0;
      core_ctrl  = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               if (req_tuser) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + BYTE_BITS;
                  pos_in   = pos_ff + 6'd1;
               end
               mark_in = 1'b1;
               pend_in = req_tlast;
               if (req_tuser && pos_ff == POS_LAST) begin
                  core_ctrl.start = 1'b1;
                  state_in        = ST_HASH;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_HASH: begin
            if (core_stat.done) begin
               state_in = pend_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            if (mark_ff || pos_ff != POS_LEN) begin
               wr_en   = 1'b1;
               wr_byte = mark_ff ? PAD_MARK : PAD_ZERO;
               mark_in = 1'b0;
               pos_in  = pos_ff + 6'd1;
               if (pos_ff == POS_LAST) begin
                  core_ctrl.start = 1'b1;
                  state_in        = ST_HASH;
               end
            end else begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            len_wr          = 1'b1;
            pos_in          = '0;
            core_ctrl.start = 1'b1;
            state_in        = ST_FINAL;
         end
         ST_FINAL: begin
            if (core_stat.done) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_acc) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == OUT_LAST) begin
                  core_ctrl.restore = 1'b1;
                  count_in          = '0;
                  pos_in            = '0;
                  pend_in           = 1'b0;
                  idx_in            = '0;
                  state_in          = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         mark_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         mark_ff  <= mark_in;
         idx_ff   <= idx_in;
      end
   end

   // byte placement, big-endian within each word
   assign wr_word  = pos_ff[5:2];
   assign wr_lane  = pos_ff[1:0];
   assign lane_val = {wr_byte, 24'h000000} >> {wr_lane, 3'b000};

   // block buffer: first byte of a word overwrites it, later bytes merge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_lane == 2'd0) begin
            block_ff[wr_word] <= lane_val;
         end else begin
            block_ff[wr_word] <= block_ff[wr_word] | lane_val;
         end
      end
      if (len_wr) begin
         block_ff[14] <= count_ff[63:32];
         block_ff[15] <= count_ff[31:0];
      end
   end

   sha1_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (core_ctrl),
      .block_words (block_ff),
      .stat        (core_stat),
      .chain       (chain)
   );

   // digest output straight from the chaining registers
   always_comb begin
      rsp_tdata = chain[0];
      case (idx_ff)
         3'd0:    rsp_tdata = chain[0];
         3'd1:    rsp_tdata = chain[1];
         3'd2:    rsp_tdata = chain[2];
         3'd3:    rsp_tdata = chain[3];
         3'd4:    rsp_tdata = chain[4];
         default: rsp_tdata = chain[0];
      endcase
   end
   assign rsp_tlast = (idx_ff == OUT_LAST);

`ifndef NO_ASSERTIONS
   // never take a request while digest words are going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request accepted during digest output");

   // the core finishes only while the sequencer waits on it
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> (state_ff == ST_HASH || state_ff == ST_FINAL))
      else $error("compression finished in an unexpected state");

   // length words go in only with the buffer at the length slot
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (pos_ff == POS_LEN && !mark_ff))
      else $error("length written at wrong byte position");

   // after the last digest word the block is ready for a new message
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && count_ff == 64'd0))
      else $error("not ready after digest output");
`endif

endmodule

// ===== sv/sha1_core.sv =====
// ----------------------------------------------------------------------------
// sha1_core: SHA-1 compression, one round per cycle
// Holds the chaining value, the five working variables and a 16-word
// message schedule shift line; per block a load step (the block buffer
// has taken its last write by then), 80 round steps and an add step.
// ----------------------------------------------------------------------------
module sha1_core
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   input  block_type     block_words,
   output core_stat_type stat,
   output chain_type     chain
);

   core_state_type state_ff, state_in;
   logic [6:0]     round_ff, round_in;
   chain_type      chain_ff, chain_in;
   chain_type      work_ff, work_in;
   block_type      sched_ff, sched_in;

   word_type f_val;
   word_type k_val;
   word_type t_val;
   word_type w_new;
   word_type a_v, b_v, c_v, d_v, e_v;

   // round function and constant by group
   always_comb begin
      a_v = work_ff[0];
      b_v = work_ff[1];
      c_v = work_ff[2];
      d_v = work_ff[3];
      e_v = work_ff[4];
      if (round_ff < ROUND_GROUP1) begin
         f_val = (b_v & c_v) | (~b_v & d_v);
         k_val = K_GROUP0;
      end else if (round_ff < ROUND_GROUP2) begin
         f_val = b_v ^ c_v ^ d_v;
         k_val = K_GROUP1;
      end else if (round_ff < ROUND_GROUP3) begin
         f_val = (b_v & c_v) | (b_v & d_v) | (c_v & d_v);
         k_val = K_GROUP2;
      end else begin
         f_val = b_v ^ c_v ^ d_v;
         k_val = K_GROUP3;
      end
      t_val = {a_v[26:0], a_v[31:27]} + f_val + e_v + k_val + sched_ff[0];
      w_new = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   end

   // sequencer and next values
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      stat     = '0;
      case (state_ff)
         CORE_IDLE: begin
            if (ctrl.restore) begin
               chain_in = SHA_INIT;
            end
            if (ctrl.start) begin
               state_in = CORE_LOAD;
            end
         end
         CORE_LOAD: begin
            stat.busy = 1'b1;
            work_in   = chain_ff;
            sched_in  = block_words;
            round_in  = '0;
            state_in  = CORE_ROUND;
         end
         CORE_ROUND: begin
            stat.busy = 1'b1;
            work_in[4] = d_v;
            work_in[3] = c_v;
            work_in[2] = {b_v[1:0], b_v[31:2]};
            work_in[1] = a_v;
            work_in[0] = t_val;
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i+1];
            end
            sched_in[15] = {w_new[30:0], w_new[31]};
            round_in = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = CORE_ADD;
            end
         end
         CORE_ADD: begin
            stat.busy = 1'b1;
            stat.done = 1'b1;
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= '0;
         chain_ff <= SHA_INIT;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   // working variables and schedule
   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign chain = chain_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the streaming SHA-1 message hasher
// Sends messages a byte per request, with ignored requests mixed in. Digest
// words are checked against a SHA-1 model kept in the bench, or against
// known digests for the empty message and "abc". Sender and receiver idle
// at random, and the receiver once holds off long enough to stall the input.
// A message of 2^61 bytes would be needed to wrap the bit count, so that
// case is not driven.
// ----------------------------------------------------------------------------
module tb;

   typedef logic [4:0][31:0]  digest_t;    // word j is H_j
   typedef logic [15:0][31:0] msg_block_t;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_beat_t;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
      logic       known;
      digest_t    digest;
   } stim_row_t;

   // SHA-1 initial chaining value, H4 down to H0
   localparam digest_t CHAIN_START = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };
   localparam logic [31:0] K_ROUNDS_00 = 32'h5A827999;
   localparam logic [31:0] K_ROUNDS_20 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUNDS_40 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUNDS_60 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [5:0]  LEN_SLOT    = 6'd56;

   // well-known digests, H4 down to H0
   localparam digest_t EMPTY_DIGEST = {
      32'hAFD80709, 32'h95601890, 32'h3255BFEF, 32'h5E6B4B0D, 32'hDA39A3EE
   };
   localparam digest_t ABC_DIGEST = {
      32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571, 32'h4706816A, 32'hA9993E36
   };

   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 500;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // byte_present
   logic        req_tlast;   // message_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] digest_word
   logic        rsp_tlast;   // digest_last

   // request side-band: typed digest that goes with the current request
   logic        row_known;
   digest_t     row_digest;

   // hash model state
   digest_t      hash_chain;
   msg_block_t   msg_block;
   logic [5:0]   fill_pos;
   logic [63:0]  bit_total;
   digest_beat_t expected_digest[$];

   stim_row_t stim_table[$];
   int        error_count = 0;
   int        drive_phase = 0;
   logic      hold_done = 1'b0;

   sha1_message_hasher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic [31:0] rotl32(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // 80 rounds over msg_block, then fold the result into the chaining value
   function automatic void compress_into_chain();
      msg_block_t  sched;
      logic [31:0] a, b, c, d, e, f, k, t;
      int          r, s;
      sched = msg_block;
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (r = 0; r < 80; r++) begin
         s = r % 16;
         if (r >= 16)
            sched[s] = rotl32(sched[(s + 13) % 16] ^ sched[(s + 8) % 16] ^
                              sched[(s + 2) % 16] ^ sched[s], 1);
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUNDS_00;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUNDS_20;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUNDS_40;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUNDS_60;
         end
         t = rotl32(a, 5) + f + e + k + sched[s];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   // big-endian byte packing; a full block is compressed at once
   function automatic void pack_byte(logic [7:0] value);
      logic [31:0] lane_word;
      lane_word = {24'h0, value} << ((3 - fill_pos[1:0]) * 8);
      if (fill_pos[1:0] == 2'd0)
         msg_block[fill_pos[5:2]] = lane_word;
      else
         msg_block[fill_pos[5:2]] |= lane_word;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0)
         compress_into_chain();
   endfunction

   function automatic void restart_message();
      hash_chain = CHAIN_START;
      bit_total  = 64'd0;
      fill_pos   = 6'd0;
   endfunction

   // apply one accepted request; at message end queue the five digest words
   function automatic void absorb_request(logic [7:0] data, logic present,
                                          logic last, logic known,
                                          digest_t typed);
      logic [63:0]  len;
      digest_beat_t beat;
      int           j;
      if (present) begin
         pack_byte(data);
         bit_total += 64'd8;
      end
      if (last) begin
         len = bit_total;
         pack_byte(PAD_BYTE);
         while (fill_pos != LEN_SLOT)
            pack_byte(8'h00);
         msg_block[14] = len[63:32];
         msg_block[15] = len[31:0];
         fill_pos = 6'd0;
         compress_into_chain();
         for (j = 0; j < 5; j++) begin
            beat.word = known ? typed[j] : hash_chain[j];
            beat.last = (j == 4);
            expected_digest = {expected_digest, beat};
         end
         restart_message();
      end
   endfunction

   function automatic void add_row(logic [7:0] data, logic present, logic last,
                                   logic known, digest_t digest);
      stim_row_t row;
      row.data    = data;
      row.present = present;
      row.last    = last;
      row.known   = known;
      row.digest  = digest;
      stim_table = {stim_table, row};
   endfunction

   // monitor: model update on accepted requests, check on accepted digests
   always @(posedge clock) begin
      digest_beat_t want;
      if (reset) begin
         restart_message();
      end else begin
         if (req_tvalid && req_tready)
            absorb_request(req_tdata, req_tuser, req_tlast, row_known, row_digest);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digest.size() == 0) begin
               report_mismatch("digest word with none expected", rsp_tdata, 32'h0);
            end else begin
               want = expected_digest.pop_front();
               if (rsp_tdata !== want.word)
                  report_mismatch("digest_word", rsp_tdata, want.word);
               if (rsp_tlast !== want.last)
                  report_mismatch("digest_last", {31'h0, rsp_tlast}, {31'h0, want.last});
            end
         end
      end
   end

   // offer one request at a falling edge; returns at the falling edge after
   // it has been accepted
   task automatic offer_request(input logic [7:0] data, input logic present,
                                input logic last, input logic known,
                                input digest_t digest);
      int idle_pct;
      idle_pct = (drive_phase == 0) ? 21 : (drive_phase == 1) ? 77 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= last;
      row_known  <= known;
      row_digest <= digest;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random back-pressure, plus one long hold-off in the last phase
   initial begin
      int hold_count;
      int idle_pct;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (drive_phase == 2 && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(negedge clock);
         end
         idle_pct = (drive_phase == 0) ? 77 : (drive_phase == 1) ? 21 : 0;
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // sender: directed table, then random messages
   initial begin
      int   row_idx;
      int   random_items;
      int   msg_len;
      int   pick;
      int   k;
      int   wait_cycles;
      logic carry_end;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      row_known  = 1'b0;
      row_digest = '0;

      // ignored request, then the empty message
      add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
      // "abc" with the end riding on the last byte, noise in between
      add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hA5, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST);
      // "abc" again, closed by a separate end request with junk data
      add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h63, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h7E, 1'b0, 1'b1, 1'b1, ABC_DIGEST);
      // byte extremes
      add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h7F, 1'b1, 1'b1, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
      // back-to-back empty message with all data bits set
      add_row(8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row_idx = 0; row_idx < stim_table.size(); row_idx++)
         offer_request(stim_table[row_idx].data, stim_table[row_idx].present,
                       stim_table[row_idx].last, stim_table[row_idx].known,
                       stim_table[row_idx].digest);

      // random messages: mostly short, some on the padding boundaries,
      // some spanning up to three blocks
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         drive_phase = (random_items * 3) / RANDOM_ITEMS;
         pick = $urandom_range(99);
         if (pick < 55) begin
            msg_len = $urandom_range(12);
         end else if (pick < 80) begin
            case ($urandom_range(5))
               0: msg_len = 55;
               1: msg_len = 56;
               2: msg_len = 63;
               3: msg_len = 64;
               4: msg_len = 119;
               default: msg_len = 120;
            endcase
         end else begin
            msg_len = $urandom_range(130, 13);
         end
         carry_end = 1'($urandom_range(1));
         for (k = 0; k < msg_len; k++) begin
            if ($urandom_range(99) < 8)
               offer_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
            offer_request(8'($urandom_range(255)), 1'b1,
                          carry_end && (k == msg_len - 1), 1'b0, '0);
            random_items++;
         end
         if (!(carry_end && msg_len > 0)) begin
            offer_request(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
            random_items++;
         end
      end
      req_tvalid <= 1'b0;

      // drain the outstanding digests, then watch for stray words
      wait_cycles = 0;
      while (expected_digest.size() != 0 && wait_cycles < 50000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_digest.size() != 0)
         report_mismatch("digest words never returned",
                         32'(expected_digest.size()), 32'h0);
      repeat (200) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sha1_pkg.sv
sv/sha1_core.sv
sv/sha1_message_hasher.sv
tb/tb.sv
